@@ sv/sspr_pkg.sv @@
// ----------------------------------------------------------------------------
// sspr_pkg
// Shared types and constants for the servo status packet receiver.
// ----------------------------------------------------------------------------
package sspr_pkg;

   localparam logic [7:0] HEADER_BYTE = 8'hFF;
   localparam logic [7:0] LEN_OVERHEAD = 8'd2;

   localparam logic OP_BYTE    = 1'b0;
   localparam logic OP_TIMEOUT = 1'b1;

   localparam logic KIND_PARAM  = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   localparam logic CSR_EXPECTED_ID    = 1'b0;
   localparam logic CSR_EXPECTED_COUNT = 1'b1;

   typedef enum logic [2:0] {
      PH_HUNT   = 3'd0,
      PH_HDR2   = 3'd1,
      PH_ID     = 3'd2,
      PH_LEN    = 3'd3,
      PH_STATUS = 3'd4,
      PH_PARAMS = 3'd5,
      PH_CHECK  = 3'd6
   } phase_type;

   typedef struct packed {
      logic       op;
      logic [7:0] rx_byte;
      logic       rx_fault;
   } req_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] param_index;
      logic [7:0] param_value;
      logic [7:0] device_error;
      logic [7:0] received_id;
      logic       id_mismatch;
      logic       length_mismatch;
      logic       checksum_bad;
      logic       header_bad;
      logic       timed_out;
      logic       line_error;
      logic       last;
   } rsp_type;

endpackage

@@ sv/servo_status_packet_receiver_top.sv @@
// ----------------------------------------------------------------------------
// servo_status_packet_receiver_top
// Status packet receiver for a half-duplex servo bus.
// ----------------------------------------------------------------------------
// One request (a received byte or a timeout) is taken every clock cycle while
// req_stall is low. A request lands in an input register, is decoded against
// the parser state combinationally and its result, if any, lands in the output
// register, which drives the rsp_ ports. The output register stalls the input
// register only while a result waits under rsp_stall. csr_ready is always
// high; write the expected id and parameter count only while no request is in
// flight.
// ----------------------------------------------------------------------------
module servo_status_packet_receiver_top (
   input  logic       clock,
   input  logic       reset,

   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_op,
   input  logic [7:0] req_rx_byte,
   input  logic       req_rx_fault,

   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_kind,
   output logic [7:0] rsp_param_index,
   output logic [7:0] rsp_param_value,
   output logic [7:0] rsp_device_error,
   output logic [7:0] rsp_received_id,
   output logic       rsp_id_mismatch,
   output logic       rsp_length_mismatch,
   output logic       rsp_checksum_bad,
   output logic       rsp_header_bad,
   output logic       rsp_timed_out,
   output logic       rsp_line_error,
   output logic       rsp_last,

   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata
);

   logic       in_valid_ff, in_valid_in;
   sspr_pkg::req_type in_req_ff;
   logic       out_valid_ff, out_valid_in;
   sspr_pkg::rsp_type out_rsp_ff;
   logic [7:0] expected_id_ff;
   logic [7:0] expected_count_ff;

   logic       advance;
   logic       req_take;
   logic       step_valid;
   sspr_pkg::rsp_type step_rsp;

   assign advance   = in_valid_ff & (~out_valid_ff | ~rsp_stall);
   assign req_stall = in_valid_ff & ~advance;
   assign req_take  = req_valid & ~req_stall;
   assign csr_ready = 1'b1;

   assign in_valid_in  = req_take | (in_valid_ff & ~advance);
   assign out_valid_in = advance ? step_valid : (out_valid_ff & rsp_stall);

   sspr_parser u_parser (
      .clock                (clock),
      .reset                (reset),
      .step                 (advance),
      .req                  (in_req_ff),
      .expected_id          (expected_id_ff),
      .expected_param_count (expected_count_ff),
      .result_valid         (step_valid),
      .result               (step_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_req_ff.op       <= req_op;
         in_req_ff.rx_byte  <= req_rx_byte;
         in_req_ff.rx_fault <= req_rx_fault;
      end
      if (advance && step_valid) begin
         out_rsp_ff <= step_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_id_ff    <= 8'd1;
         expected_count_ff <= 8'd0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            sspr_pkg::CSR_EXPECTED_ID:    expected_id_ff    <= csr_wdata;
            sspr_pkg::CSR_EXPECTED_COUNT: expected_count_ff <= csr_wdata;
            default: begin
               expected_id_ff <= expected_id_ff;
            end
         endcase
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_kind            = out_rsp_ff.kind;
   assign rsp_param_index     = out_rsp_ff.param_index;
   assign rsp_param_value     = out_rsp_ff.param_value;
   assign rsp_device_error    = out_rsp_ff.device_error;
   assign rsp_received_id     = out_rsp_ff.received_id;
   assign rsp_id_mismatch     = out_rsp_ff.id_mismatch;
   assign rsp_length_mismatch = out_rsp_ff.length_mismatch;
   assign rsp_checksum_bad    = out_rsp_ff.checksum_bad;
   assign rsp_header_bad      = out_rsp_ff.header_bad;
   assign rsp_timed_out       = out_rsp_ff.timed_out;
   assign rsp_line_error      = out_rsp_ff.line_error;
   assign rsp_last            = out_rsp_ff.last;

endmodule

@@ sv/sspr_parser.sv @@
// ----------------------------------------------------------------------------
// sspr_parser
// Packet parser state and the one-step decode of a byte or timeout request.
// ----------------------------------------------------------------------------
module sspr_parser (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  sspr_pkg::req_type req,
   input  logic [7:0]       expected_id,
   input  logic [7:0]       expected_param_count,
   output logic             result_valid,
   output sspr_pkg::rsp_type result
);

   sspr_pkg::phase_type phase_ff, phase_in;
   logic       fault_ff, fault_in;
   logic [7:0] id_ff, id_in;
   logic [7:0] length_ff, length_in;
   logic [7:0] status_ff, status_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] left_ff, left_in;
   logic [7:0] position_ff, position_in;

   logic       fault_any;
   logic [7:0] sum_add;
   logic [8:0] expected_len;

   assign fault_any    = fault_ff | req.rx_fault;
   assign sum_add      = sum_ff + req.rx_byte;
   assign expected_len = {1'b0, expected_param_count} + {1'b0, sspr_pkg::LEN_OVERHEAD};

   always_comb begin
      phase_in    = phase_ff;
      fault_in    = fault_ff;
      id_in       = id_ff;
      length_in   = length_ff;
      status_in   = status_ff;
      sum_in      = sum_ff;
      left_in     = left_ff;
      position_in = position_ff;
      if (req.op == sspr_pkg::OP_TIMEOUT) begin
         phase_in = sspr_pkg::PH_HUNT;
         fault_in = 1'b0;
      end else begin
         case (phase_ff)
            sspr_pkg::PH_HUNT: begin
               if (req.rx_byte == sspr_pkg::HEADER_BYTE) begin
                  phase_in = sspr_pkg::PH_HDR2;
                  fault_in = req.rx_fault;
               end
            end
            sspr_pkg::PH_HDR2: begin
               if (req.rx_byte != sspr_pkg::HEADER_BYTE) begin
                  phase_in = sspr_pkg::PH_HUNT;
                  fault_in = 1'b0;
               end else begin
                  phase_in = sspr_pkg::PH_ID;
                  fault_in = fault_any;
               end
            end
            sspr_pkg::PH_ID: begin
               id_in    = req.rx_byte;
               sum_in   = req.rx_byte;
               fault_in = fault_any;
               phase_in = sspr_pkg::PH_LEN;
            end
            sspr_pkg::PH_LEN: begin
               length_in = req.rx_byte;
               sum_in    = sum_add;
               fault_in  = fault_any;
               phase_in  = sspr_pkg::PH_STATUS;
            end
            sspr_pkg::PH_STATUS: begin
               status_in   = req.rx_byte;
               sum_in      = sum_add;
               fault_in    = fault_any;
               position_in = 8'd0;
               if (length_ff > sspr_pkg::LEN_OVERHEAD) begin
                  left_in  = length_ff - sspr_pkg::LEN_OVERHEAD;
                  phase_in = sspr_pkg::PH_PARAMS;
               end else begin
                  left_in  = 8'd0;
                  phase_in = sspr_pkg::PH_CHECK;
               end
            end
            sspr_pkg::PH_PARAMS: begin
               sum_in      = sum_add;
               fault_in    = fault_any;
               position_in = position_ff + 8'd1;
               left_in     = left_ff - 8'd1;
               if (left_ff == 8'd1) begin
                  phase_in = sspr_pkg::PH_CHECK;
               end
            end
            sspr_pkg::PH_CHECK: begin
               phase_in = sspr_pkg::PH_HUNT;
               fault_in = 1'b0;
            end
            default: begin
               phase_in = sspr_pkg::PH_HUNT;
               fault_in = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      result_valid = 1'b0;
      result       = '0;
      if (req.op == sspr_pkg::OP_TIMEOUT) begin
         result_valid      = 1'b1;
         result.kind       = sspr_pkg::KIND_STATUS;
         result.last       = 1'b1;
         result.timed_out  = 1'b1;
         result.line_error = (phase_ff != sspr_pkg::PH_HUNT) & fault_ff;
      end else begin
         case (phase_ff)
            sspr_pkg::PH_HDR2: begin
               if (req.rx_byte != sspr_pkg::HEADER_BYTE) begin
                  result_valid      = 1'b1;
                  result.kind       = sspr_pkg::KIND_STATUS;
                  result.last       = 1'b1;
                  result.header_bad = 1'b1;
                  result.line_error = fault_any;
               end
            end
            sspr_pkg::PH_PARAMS: begin
               result_valid       = 1'b1;
               result.kind        = sspr_pkg::KIND_PARAM;
               result.param_index = position_ff;
               result.param_value = req.rx_byte;
            end
            sspr_pkg::PH_CHECK: begin
               result_valid           = 1'b1;
               result.kind            = sspr_pkg::KIND_STATUS;
               result.last            = 1'b1;
               result.device_error    = status_ff;
               result.received_id     = id_ff;
               result.id_mismatch     = id_ff != expected_id;
               result.length_mismatch = {1'b0, length_ff} != expected_len;
               result.checksum_bad    = req.rx_byte != ~sum_ff;
               result.line_error      = fault_any;
            end
            default: begin
               result_valid = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= sspr_pkg::PH_HUNT;
         fault_ff <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         fault_ff <= fault_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         id_ff       <= id_in;
         length_ff   <= length_in;
         status_ff   <= status_in;
         sum_ff      <= sum_in;
         left_ff     <= left_in;
         position_ff <= position_in;
      end
   end

endmodule

@@ sv/sspr_checker.sv @@
// ----------------------------------------------------------------------------
// sspr_checker
// Port-level checks for the servo status packet receiver, bound to the top.
// ----------------------------------------------------------------------------
module sspr_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_kind,
   input logic [7:0] rsp_param_index,
   input logic [7:0] rsp_param_value,
   input logic [7:0] rsp_device_error,
   input logic [7:0] rsp_received_id,
   input logic       rsp_id_mismatch,
   input logic       rsp_length_mismatch,
   input logic       rsp_checksum_bad,
   input logic       rsp_header_bad,
   input logic       rsp_timed_out,
   input logic       rsp_line_error,
   input logic       rsp_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind)
         && $stable(rsp_param_value) && $stable(rsp_received_id))
      else $error("stalled response changed");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_param_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_kind |-> !rsp_last && rsp_device_error == 8'd0
         && rsp_received_id == 8'd0 && !rsp_timed_out && !rsp_header_bad
         && !rsp_id_mismatch && !rsp_length_mismatch && !rsp_checksum_bad
         && !rsp_line_error)
      else $error("parameter response carries status flags");

   a_status_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind |-> rsp_last && rsp_param_index == 8'd0
         && rsp_param_value == 8'd0)
      else $error("status response carries parameter data");

   a_abort_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_timed_out || rsp_header_bad) |-> !(rsp_timed_out && rsp_header_bad)
         && rsp_received_id == 8'd0 && rsp_device_error == 8'd0
         && !rsp_id_mismatch && !rsp_checksum_bad && !rsp_length_mismatch)
      else $error("aborted packet reports packet contents");

endmodule

bind servo_status_packet_receiver_top sspr_checker u_sspr_checker (.*);
